@@ hw/rtl/software_timer_queue_defines.svh @@
// ----------------------------------------------------------------------------
// Software timer queue assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef SOFTWARE_TIMER_QUEUE_DEFINES_SVH
`define SOFTWARE_TIMER_QUEUE_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define STQ_ASSERT_SAME(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define STQ_ASSERT_NEXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ hw/rtl/stq_pkg.sv @@
// ----------------------------------------------------------------------------
// Software timer queue package
// Field widths, command and result codes, controller states and the
// control bundle that drives the slot scanner.
// ----------------------------------------------------------------------------
package stq_pkg;

	localparam int CMD_W  = 2;
	localparam int ID_W   = 32;
	localparam int TIME_W = 40;
	localparam int KIND_W = 3;

	typedef enum logic [CMD_W-1:0] {
		CMD_CREATE = 2'd0,
		CMD_DELETE = 2'd1,
		CMD_TICK   = 2'd2
	} cmd_t;

	typedef enum logic [KIND_W-1:0] {
		KIND_FIRED       = 3'd0,
		KIND_ACCEPTED    = 3'd1,
		KIND_DELETED     = 3'd2,
		KIND_NOT_FOUND   = 3'd3,
		KIND_FULL        = 3'd4,
		KIND_NOTHING_DUE = 3'd5
	} kind_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CREATE,
		ST_SCAN,
		ST_DRAIN,
		ST_DECIDE
	} state_t;

	typedef struct packed {
		logic clear;
		logic strobe;
		logic tick_mode;
	} scan_ctl_t;

endpackage

@@ hw/rtl/software_timer_queue.sv @@
// ----------------------------------------------------------------------------
// Software timer queue
// Up to CAPACITY timers kept in a slot memory. A create takes the lowest free
// slot; delete and tick commands are served by full scans, one slot per cycle.
//
//   Channel   Handshake              Payload
//   command   cmd_valid/cmd_ready    command timer_id duration start_time
//                                    repeat_req now
//   result    res_valid/res_ready    result_kind fired_id queue_empty last
//
// A delete makes one full pass over the memory, and a tick that fires timers
// makes one full pass over the single memory read port for each fired timer,
// or one pass if none is due.
// Commands are taken only while the sequencer is idle; a waiting result sits
// in the output register, and a new command can be accepted meanwhile.
// Reset clears all slot valid bits; slot contents need no clearing.
// ----------------------------------------------------------------------------
module software_timer_queue #(
	parameter int unsigned CAPACITY  = 32,
	parameter int unsigned TIME_BITS = 40,
	parameter int unsigned ID_BITS   = 32
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cmd_valid,
	output logic                         cmd_ready,
	input  logic [stq_pkg::CMD_W-1:0]    command,
	input  logic [stq_pkg::ID_W-1:0]     timer_id,
	input  logic [stq_pkg::TIME_W-1:0]   duration,
	input  logic [stq_pkg::TIME_W-1:0]   start_time,
	input  logic                         repeat_req,
	input  logic [stq_pkg::TIME_W-1:0]   now,
	output logic                         res_valid,
	input  logic                         res_ready,
	output logic [stq_pkg::KIND_W-1:0]   result_kind,
	output logic [stq_pkg::ID_W-1:0]     fired_id,
	output logic                         queue_empty,
	output logic                         last
);

	import stq_pkg::*;

	localparam int unsigned AW = $clog2(CAPACITY);
	localparam int unsigned CW = $clog2(CAPACITY + 1);
	localparam int unsigned EW = ID_BITS + 2 * TIME_BITS + 1;

	logic                 rd_en;
	logic [AW-1:0]        rd_addr;
	logic [EW-1:0]        rd_data;
	logic                 wr_en;
	logic [AW-1:0]        wr_addr;
	logic [EW-1:0]        wr_data;
	scan_ctl_t            scan_ctl;
	logic                 slot_vld;
	logic [AW-1:0]        slot_s1;
	logic [ID_BITS-1:0]   key_id;
	logic [TIME_BITS-1:0] now_ref;
	logic                 found;
	logic [AW-1:0]        best_slot;
	logic [ID_BITS-1:0]   best_id;
	logic [TIME_BITS-1:0] best_period;
	logic                 best_repeat;
	logic [CW-1:0]        due_cnt;
	logic                 survivor;

	stq_slot_ram #(
		.DEPTH (CAPACITY),
		.WIDTH (EW)
	) u_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	stq_scan #(
		.CAPACITY  (CAPACITY),
		.TIME_BITS (TIME_BITS),
		.ID_BITS   (ID_BITS)
	) u_scan (
		.clk         (clk),
		.arst_n      (arst_n),
		.ctl         (scan_ctl),
		.slot_vld    (slot_vld),
		.slot        (slot_s1),
		.rd_data     (rd_data),
		.key_id      (key_id),
		.now         (now_ref),
		.found       (found),
		.best_slot   (best_slot),
		.best_id     (best_id),
		.best_period (best_period),
		.best_repeat (best_repeat),
		.due_cnt     (due_cnt),
		.survivor    (survivor)
	);

	stq_ctrl #(
		.CAPACITY  (CAPACITY),
		.TIME_BITS (TIME_BITS),
		.ID_BITS   (ID_BITS)
	) u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd_valid   (cmd_valid),
		.cmd_ready   (cmd_ready),
		.command     (command),
		.timer_id    (timer_id),
		.duration    (duration),
		.start_time  (start_time),
		.repeat_req  (repeat_req),
		.now         (now),
		.res_valid   (res_valid),
		.res_ready   (res_ready),
		.result_kind (result_kind),
		.fired_id    (fired_id),
		.queue_empty (queue_empty),
		.last        (last),
		.rd_en       (rd_en),
		.rd_addr     (rd_addr),
		.wr_en       (wr_en),
		.wr_addr     (wr_addr),
		.wr_data     (wr_data),
		.scan_ctl    (scan_ctl),
		.slot_vld    (slot_vld),
		.slot_s1     (slot_s1),
		.key_id      (key_id),
		.now_ref     (now_ref),
		.found       (found),
		.best_slot   (best_slot),
		.best_id     (best_id),
		.best_period (best_period),
		.best_repeat (best_repeat),
		.due_cnt     (due_cnt),
		.survivor    (survivor)
	);

endmodule

@@ hw/rtl/stq_slot_ram.sv @@
// ----------------------------------------------------------------------------
// Slot memory
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module stq_slot_ram #(
	parameter int unsigned DEPTH = 32,
	parameter int unsigned WIDTH = 113,
	localparam int unsigned AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

@@ hw/rtl/stq_scan.sv @@
// ----------------------------------------------------------------------------
// Slot scanner
// Consumes one slot record per cycle while strobed and keeps the earliest
// matching slot, the due timer count and whether any timer outlives the tick.
// ----------------------------------------------------------------------------
module stq_scan #(
	parameter int unsigned CAPACITY  = 32,
	parameter int unsigned TIME_BITS = 40,
	parameter int unsigned ID_BITS   = 32,
	localparam int unsigned AW = $clog2(CAPACITY),
	localparam int unsigned CW = $clog2(CAPACITY + 1),
	localparam int unsigned EW = ID_BITS + 2 * TIME_BITS + 1
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  stq_pkg::scan_ctl_t    ctl,
	input  logic                  slot_vld,
	input  logic [AW-1:0]         slot,
	input  logic [EW-1:0]         rd_data,
	input  logic [ID_BITS-1:0]    key_id,
	input  logic [TIME_BITS-1:0]  now,
	output logic                  found,
	output logic [AW-1:0]         best_slot,
	output logic [ID_BITS-1:0]    best_id,
	output logic [TIME_BITS-1:0]  best_period,
	output logic                  best_repeat,
	output logic [CW-1:0]         due_cnt,
	output logic                  survivor
);

	import stq_pkg::*;

	logic [ID_BITS-1:0]   e_id;
	logic [TIME_BITS-1:0] e_target;
	logic [TIME_BITS-1:0] e_period;
	logic                 e_rep;
	logic                 due;
	logic                 hit;
	logic                 better;

	logic                 found_q;
	logic [CW-1:0]        cnt_q;
	logic                 surv_q;
	logic [AW-1:0]        best_slot_q;
	logic [ID_BITS-1:0]   best_id_q;
	logic [TIME_BITS-1:0] best_target_q;
	logic [TIME_BITS-1:0] best_period_q;
	logic                 best_rep_q;

	assign e_id     = rd_data[EW-1 -: ID_BITS];
	assign e_target = rd_data[2*TIME_BITS -: TIME_BITS];
	assign e_period = rd_data[TIME_BITS -: TIME_BITS];
	assign e_rep    = rd_data[0];

	always_comb begin
		due    = slot_vld && (e_target < now);
		hit    = ctl.tick_mode ? due : (slot_vld && (e_id == key_id));
		better = hit && (!found_q || (e_target < best_target_q));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q <= 1'b0;
			cnt_q   <= '0;
			surv_q  <= 1'b0;
		end else if (ctl.clear) begin
			found_q <= 1'b0;
			cnt_q   <= '0;
			surv_q  <= 1'b0;
		end else if (ctl.strobe) begin
			if (better) begin
				found_q <= 1'b1;
			end
			if (ctl.tick_mode && due) begin
				cnt_q <= cnt_q + CW'(1);
			end
			if (slot_vld && (!due || e_rep)) begin
				surv_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.strobe && better) begin
			best_slot_q   <= slot;
			best_id_q     <= e_id;
			best_target_q <= e_target;
			best_period_q <= e_period;
			best_rep_q    <= e_rep;
		end
	end

	assign found       = found_q;
	assign best_slot   = best_slot_q;
	assign best_id     = best_id_q;
	assign best_period = best_period_q;
	assign best_repeat = best_rep_q;
	assign due_cnt     = cnt_q;
	assign survivor    = surv_q;

endmodule

@@ hw/rtl/stq_ctrl.sv @@
// ----------------------------------------------------------------------------
// Timer queue controller
// Command sequencer, slot valid bits, memory access control and the
// result register.
// ----------------------------------------------------------------------------
`include "software_timer_queue_defines.svh"

module stq_ctrl #(
	parameter int unsigned CAPACITY  = 32,
	parameter int unsigned TIME_BITS = 40,
	parameter int unsigned ID_BITS   = 32,
	localparam int unsigned AW = $clog2(CAPACITY),
	localparam int unsigned CW = $clog2(CAPACITY + 1),
	localparam int unsigned EW = ID_BITS + 2 * TIME_BITS + 1
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cmd_valid,
	output logic                         cmd_ready,
	input  logic [stq_pkg::CMD_W-1:0]    command,
	input  logic [stq_pkg::ID_W-1:0]     timer_id,
	input  logic [stq_pkg::TIME_W-1:0]   duration,
	input  logic [stq_pkg::TIME_W-1:0]   start_time,
	input  logic                         repeat_req,
	input  logic [stq_pkg::TIME_W-1:0]   now,
	output logic                         res_valid,
	input  logic                         res_ready,
	output logic [stq_pkg::KIND_W-1:0]   result_kind,
	output logic [stq_pkg::ID_W-1:0]     fired_id,
	output logic                         queue_empty,
	output logic                         last,
	output logic                         rd_en,
	output logic [AW-1:0]                rd_addr,
	output logic                         wr_en,
	output logic [AW-1:0]                wr_addr,
	output logic [EW-1:0]                wr_data,
	output stq_pkg::scan_ctl_t           scan_ctl,
	output logic                         slot_vld,
	output logic [AW-1:0]                slot_s1,
	output logic [ID_BITS-1:0]           key_id,
	output logic [TIME_BITS-1:0]         now_ref,
	input  logic                         found,
	input  logic [AW-1:0]                best_slot,
	input  logic [ID_BITS-1:0]           best_id,
	input  logic [TIME_BITS-1:0]         best_period,
	input  logic                         best_repeat,
	input  logic [CW-1:0]                due_cnt,
	input  logic                         survivor
);

	import stq_pkg::*;

	logic [ID_BITS+ID_W-1:0]     id_ext;
	logic [TIME_BITS+TIME_W-1:0] dur_ext;
	logic [TIME_BITS+TIME_W-1:0] start_ext;
	logic [TIME_BITS+TIME_W-1:0] now_ext;

	state_t               state_q, state_d;
	cmd_t                 cmd_q;
	logic [ID_BITS-1:0]   id_q;
	logic [TIME_BITS-1:0] dur_q;
	logic [TIME_BITS-1:0] start_q;
	logic                 rep_q;
	logic [TIME_BITS-1:0] now_q;

	logic [CAPACITY-1:0]  valid_q;
	logic [AW-1:0]        addr_q, addr_d;
	logic                 strobe_s1;
	logic [AW-1:0]        slot_addr_s1;
	logic                 first_q, first_d;
	logic [CW-1:0]        remaining_q, remaining_d;
	logic                 keep_q, keep_d;

	logic                 res_valid_q;
	kind_t                kind_q;
	logic [ID_W-1:0]      res_id_q;
	logic                 res_empty_q;
	logic                 res_last_q;

	logic                 out_free;
	logic [AW-1:0]        free_slot;
	logic                 any_free;
	logic [TIME_BITS:0]   create_sum;
	logic [TIME_BITS-1:0] create_target;
	logic [TIME_BITS:0]   resched_sum;
	logic [TIME_BITS-1:0] resched_target;
	logic [CAPACITY-1:0]  best_mask;
	logic [CW-1:0]        rem;
	logic                 keep;

	logic                 load;
	kind_t                ld_kind;
	logic [ID_BITS-1:0]   ld_id;
	logic [ID_BITS+ID_W-1:0] ld_id_ext;
	logic                 ld_empty;
	logic                 ld_last;
	logic                 set_en;
	logic                 clr_en;

	assign id_ext    = {{ID_BITS{1'b0}}, timer_id};
	assign dur_ext   = {{TIME_BITS{1'b0}}, duration};
	assign start_ext = {{TIME_BITS{1'b0}}, start_time};
	assign now_ext   = {{TIME_BITS{1'b0}}, now};

	always_comb begin
		free_slot = '0;
		for (int i = CAPACITY - 1; i >= 0; i--) begin
			if (!valid_q[i]) begin
				free_slot = AW'(i);
			end
		end
	end

	assign any_free       = ~&valid_q;
	assign out_free       = !res_valid_q || res_ready;
	assign create_sum     = {1'b0, start_q} + {1'b0, dur_q};
	assign create_target  = create_sum[TIME_BITS] ? '1 : create_sum[TIME_BITS-1:0];
	assign resched_sum    = {1'b0, now_q} + {1'b0, best_period};
	assign resched_target = resched_sum[TIME_BITS] ? '1 : resched_sum[TIME_BITS-1:0];
	assign best_mask      = CAPACITY'(1) << best_slot;
	assign rem            = first_q ? due_cnt : remaining_q;
	assign keep           = first_q ? survivor : keep_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d     = state_q;
		cmd_ready   = 1'b0;
		rd_en       = 1'b0;
		wr_en       = 1'b0;
		wr_addr     = free_slot;
		wr_data     = {id_q, create_target, dur_q, rep_q};
		scan_ctl           = '0;
		scan_ctl.strobe    = strobe_s1;
		scan_ctl.tick_mode = (cmd_q == CMD_TICK);
		addr_d      = addr_q;
		first_d     = first_q;
		remaining_d = remaining_q;
		keep_d      = keep_q;
		load        = 1'b0;
		ld_kind     = KIND_FIRED;
		ld_id       = id_q;
		ld_empty    = ~|valid_q;
		ld_last     = 1'b1;
		set_en      = 1'b0;
		clr_en      = 1'b0;

		unique case (state_q)
			ST_IDLE: begin
				cmd_ready = 1'b1;
				if (cmd_valid) begin
					unique case (cmd_t'(command)) inside
						CMD_CREATE: begin
							state_d = ST_CREATE;
						end
						CMD_DELETE, CMD_TICK: begin
							state_d        = ST_SCAN;
							scan_ctl.clear = 1'b1;
							addr_d         = '0;
							first_d        = 1'b1;
						end
						default: begin
							state_d = ST_IDLE;
						end
					endcase
				end
			end
			ST_CREATE: begin
				if (out_free) begin
					load    = 1'b1;
					state_d = ST_IDLE;
					if ((dur_q == '0) && !rep_q) begin
						ld_kind = KIND_FIRED;
					end else if (!any_free) begin
						ld_kind = KIND_FULL;
					end else begin
						ld_kind  = KIND_ACCEPTED;
						ld_empty = 1'b0;
						wr_en    = 1'b1;
						set_en   = 1'b1;
					end
				end
			end
			ST_SCAN: begin
				rd_en = 1'b1;
				if (addr_q == AW'(CAPACITY - 1)) begin
					state_d = ST_DRAIN;
				end else begin
					addr_d = addr_q + AW'(1);
				end
			end
			ST_DRAIN: begin
				state_d = ST_DECIDE;
			end
			ST_DECIDE: begin
				if (out_free) begin
					load    = 1'b1;
					state_d = ST_IDLE;
					if (cmd_q == CMD_DELETE) begin
						if (found) begin
							ld_kind  = KIND_DELETED;
							ld_empty = ~|(valid_q & ~best_mask);
							clr_en   = 1'b1;
						end else begin
							ld_kind = KIND_NOT_FOUND;
						end
					end else begin
						ld_empty = ~keep;
						keep_d   = keep;
						first_d  = 1'b0;
						if (!found) begin
							ld_kind = KIND_NOTHING_DUE;
							ld_id   = '0;
						end else begin
							ld_kind     = KIND_FIRED;
							ld_id       = best_id;
							ld_last     = (rem == CW'(1));
							remaining_d = rem - CW'(1);
							if (best_repeat) begin
								wr_en   = 1'b1;
								wr_addr = best_slot;
								wr_data = {best_id, resched_target, best_period, 1'b1};
							end else begin
								clr_en = 1'b1;
							end
							if (rem != CW'(1)) begin
								state_d        = ST_SCAN;
								scan_ctl.clear = 1'b1;
								addr_d         = '0;
							end
						end
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd_valid && cmd_ready) begin
			cmd_q   <= cmd_t'(command);
			id_q    <= id_ext[ID_BITS-1:0];
			dur_q   <= dur_ext[TIME_BITS-1:0];
			start_q <= start_ext[TIME_BITS-1:0];
			rep_q   <= repeat_req;
			now_q   <= now_ext[TIME_BITS-1:0];
		end
		slot_addr_s1 <= addr_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q     <= '0;
			addr_q      <= '0;
			strobe_s1   <= 1'b0;
			first_q     <= 1'b0;
			remaining_q <= '0;
			keep_q      <= 1'b0;
		end else begin
			if (set_en) begin
				valid_q[free_slot] <= 1'b1;
			end
			if (clr_en) begin
				valid_q[best_slot] <= 1'b0;
			end
			addr_q      <= addr_d;
			strobe_s1   <= rd_en;
			first_q     <= first_d;
			remaining_q <= remaining_d;
			keep_q      <= keep_d;
		end
	end

	assign ld_id_ext = {{ID_W{1'b0}}, ld_id};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (load) begin
			res_valid_q <= 1'b1;
		end else if (res_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			kind_q      <= ld_kind;
			res_id_q    <= ld_id_ext[ID_W-1:0];
			res_empty_q <= ld_empty;
			res_last_q  <= ld_last;
		end
	end

	assign rd_addr     = addr_q;
	assign slot_s1     = slot_addr_s1;
	assign slot_vld    = valid_q[slot_addr_s1];
	assign key_id      = id_q;
	assign now_ref     = now_q;
	assign res_valid   = res_valid_q;
	assign result_kind = kind_q;
	assign fired_id    = res_id_q;
	assign queue_empty = res_empty_q;
	assign last        = res_last_q;

	`STQ_ASSERT_SAME(a_wr_no_scan, wr_en, !rd_en && !strobe_s1, "memory write during a scan")
	`STQ_ASSERT_SAME(a_create_free, wr_en && (state_q == ST_CREATE), !valid_q[wr_addr], "create overwrites a live slot")
	`STQ_ASSERT_SAME(a_tick_count, (state_q == ST_DECIDE) && scan_ctl.tick_mode && !first_q && found, remaining_q != '0, "tick fires beyond its due count")
	`STQ_ASSERT_NEXT(a_last_idle, load && ld_last, state_q == ST_IDLE, "sequencer busy after final result")

endmodule
